### hw/rtl/bmp_row_pixel_packer_assert.svh
// assertion macros for the row pixel packer checker
`ifndef BMP_ROW_PIXEL_PACKER_ASSERT_SVH
`define BMP_ROW_PIXEL_PACKER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BMP_RPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define BMP_RPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/bmp_rpp_pkg.sv
package bmp_rpp_pkg;

    // field widths
    localparam int PIXEL_W    = 8;
    localparam int BYTE_W     = 8;
    localparam int ROW_W      = 16;
    localparam int DEPTH_W    = 2;
    localparam int USER_W     = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // bit positions in m_tuser
    localparam int USER_IS_PAD = 0;
    localparam int USER_LAST   = 1;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEPTH_CODE = 1'b0,
        CFG_ROW_WIDTH  = 1'b1
    } cfg_reg_t;

    // bits per pixel codes
    typedef enum logic [DEPTH_W-1:0] {
        DEPTH_1BPP = 2'd0,
        DEPTH_2BPP = 2'd1,
        DEPTH_4BPP = 2'd2,
        DEPTH_8BPP = 2'd3
    } depth_t;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RST = 16'd1;

endpackage

### hw/rtl/bmp_row_pixel_packer.sv
// channel   dir  tdata          tuser                  tlast
// s_        in   [7:0] pixel    -                      -
// m_        out  [7:0] out_byte [0] is_pad, [1] last   row_done
// cfg_      in   write port: index 0 depth_code, index 1 row_width
//
// one pixel word is accepted per cycle while each pixel yields at most one byte;
// a row end can queue a data byte and up to three pad bytes, and the output
// buffer sends one byte a cycle, holding s_tready low until its last byte goes;
// both stall on m_tready. result appears the cycle after the pixel is accepted.
// aresetn is synchronous and active low; config takes effect on the next pixel.
module bmp_row_pixel_packer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bmp_rpp_pkg::PIXEL_W-1:0]     s_tdata,   // [7:0] pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmp_rpp_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] out_byte
    output logic [bmp_rpp_pkg::USER_W-1:0]      m_tuser,   // [0] is_pad, [1] last
    output logic                                m_tlast,   // row_done
    input  logic                                cfg_we,
    input  logic [bmp_rpp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bmp_rpp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bmp_rpp_pkg::*;

    // configuration
    depth_t           depth_reg;
    logic [ROW_W-1:0] row_width_reg;

    // packing state
    logic [BYTE_W-1:0] acc_reg, acc_next;
    logic [2:0]        bits_reg, bits_next;
    logic [1:0]        bw_reg, bw_next;
    logic [ROW_W-1:0]  col_reg, col_next;

    // output buffer: optional data byte then pad bytes
    logic              data_pend_reg, data_pend_next;
    logic [1:0]        pads_reg, pads_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              row_end_reg, row_end_next;

    logic              accept;
    logic              out_last;
    logic              out_take;
    logic [3:0]        bpp;
    logic [PIXEL_W-1:0] pix;
    logic [3:0]        filled;
    logic [15:0]       shifted;
    logic [BYTE_W-1:0] acc_new;
    logic [ROW_W-1:0]  col_inc;
    logic              row_end;
    logic              data_pres;
    logic [1:0]        bw_after;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg     <= DEPTH_8BPP;
            row_width_reg <= ROW_WIDTH_RST;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_DEPTH_CODE: depth_reg     <= depth_t'(cfg_wdata[DEPTH_W-1:0]);
                CFG_ROW_WIDTH:  row_width_reg <= cfg_wdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // output side view of the buffer
    always_comb begin
        m_tvalid = data_pend_reg || (pads_reg != 2'd0);
        out_last = data_pend_reg ? (pads_reg == 2'd0) : (pads_reg == 2'd1);
        m_tdata  = data_pend_reg ? byte_reg : '0;
        m_tuser[USER_IS_PAD] = !data_pend_reg;
        m_tuser[USER_LAST]   = out_last;
        m_tlast  = out_last && row_end_reg;
        out_take = m_tvalid && m_tready;
        s_tready = !m_tvalid || (m_tready && out_last);
        accept   = s_tvalid && s_tready;
    end

    // pixel masking and placement, msb first
    always_comb begin
        unique case (depth_reg)
            DEPTH_1BPP: begin bpp = 4'd1; pix = {7'd0, s_tdata[0]};   end
            DEPTH_2BPP: begin bpp = 4'd2; pix = {6'd0, s_tdata[1:0]}; end
            DEPTH_4BPP: begin bpp = 4'd4; pix = {4'd0, s_tdata[3:0]}; end
            DEPTH_8BPP: begin bpp = 4'd8; pix = s_tdata;              end
            default:    begin bpp = 4'd8; pix = s_tdata;              end
        endcase
        filled   = {1'b0, bits_reg} + bpp;
        shifted  = {pix, 8'h00} >> filled;
        acc_new  = acc_reg | shifted[BYTE_W-1:0];
        col_inc  = col_reg + 16'd1;
        row_end  = (col_inc >= row_width_reg) || (col_inc == '0);
        // a row end always flushes, since at least one bit is pending then
        data_pres = filled[3] || row_end;
        bw_after  = bw_reg + {1'b0, data_pres};
    end

    // next state for an accepted pixel
    always_comb begin
        acc_next       = acc_reg;
        bits_next      = bits_reg;
        bw_next        = bw_reg;
        col_next       = col_reg;
        data_pend_next = data_pend_reg;
        pads_next      = pads_reg;
        byte_next      = byte_reg;
        row_end_next   = row_end_reg;
        if (accept) begin
            acc_next       = data_pres ? '0 : acc_new;
            bits_next      = data_pres ? 3'd0 : filled[2:0];
            bw_next        = row_end ? 2'd0 : bw_after;
            col_next       = row_end ? '0 : col_inc;
            data_pend_next = data_pres;
            pads_next      = row_end ? (2'd0 - bw_after) : 2'd0;
            byte_next      = acc_new;
            row_end_next   = row_end;
        end else if (out_take) begin
            if (data_pend_reg) begin
                data_pend_next = 1'b0;
            end else begin
                pads_next = pads_reg - 2'd1;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            bits_reg      <= '0;
            bw_reg        <= '0;
            col_reg       <= '0;
            data_pend_reg <= 1'b0;
            pads_reg      <= '0;
            row_end_reg   <= 1'b0;
        end else begin
            acc_reg       <= acc_next;
            bits_reg      <= bits_next;
            bw_reg        <= bw_next;
            col_reg       <= col_next;
            data_pend_reg <= data_pend_next;
            pads_reg      <= pads_next;
            row_end_reg   <= row_end_next;
        end
    end

    // output byte payload
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

endmodule

### hw/rtl/bmp_rpp_checker.sv
`include "bmp_row_pixel_packer_assert.svh"

// port-level checks on the row pixel packer
module bmp_rpp_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bmp_rpp_pkg::BYTE_W-1:0]      m_tdata,
    input logic [bmp_rpp_pkg::USER_W-1:0]      m_tuser,
    input logic                                m_tlast
);
    import bmp_rpp_pkg::*;

    // a stalled output word holds
    `BMP_RPP_ASSERT_NEXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")
    // padding bytes are zero
    `BMP_RPP_ASSERT_NOW(a_pad_zero, m_tvalid && m_tuser[USER_IS_PAD], m_tdata == '0, "pad byte not zero")
    // a row end is always the last byte of its pixel
    `BMP_RPP_ASSERT_NOW(a_row_last, m_tvalid && m_tlast, m_tuser[USER_LAST], "row end not on last byte of pixel")
    // pads run on to the last byte of the pixel
    `BMP_RPP_ASSERT_NEXT(a_pad_run, m_tvalid && m_tready && m_tuser[USER_IS_PAD] && !m_tuser[USER_LAST], m_tvalid && m_tuser[USER_IS_PAD], "pad run broken")
    // no new pixel while words remain, unless the last one is being taken
    `BMP_RPP_ASSERT_NOW(a_in_block, m_tvalid && !(m_tready && m_tuser[USER_LAST]), !s_tready, "pixel taken while bytes pending")

endmodule

bind bmp_row_pixel_packer bmp_rpp_checker u_bmp_rpp_checker (.*);
